/* rtl/core/salct_pkg.sv */
// Shared constants, item types and row layout of the cache tag store.
package salct_pkg;

	// Geometry
	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_WIDTH   = 64;

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W    = MAX_SET_BITS;
	// Smallest split is one set bit and one offset bit
	localparam int TAG_W    = ADDR_WIDTH - 2;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W   = WAY_W;
	localparam int NW_W     = $clog2(MAX_WAYS + 1);
	localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
	localparam int BB_MAX   = 32;
	localparam int BB_W     = 6;
	localparam int SH_W     = $clog2(MAX_SET_BITS + BB_MAX + 1);
	localparam int CNT_W    = 32;

	// Configuration port
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

	// Opcodes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;
	localparam logic [1:0] OP_IFETCH = 2'd3;

	// Access queue between front and back
	localparam int QDEPTH = 2;
	localparam int Q_AW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [ADDR_WIDTH-1:0] address;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic             miss;
		logic             evicted;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] evict_total;
		logic             last_of_run;
	} rsp_t;

	// One classified access: tag, set and whether it runs twice (modify)
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [SET_W-1:0] set;
		logic             twice;
	} acc_t;

	// One set as stored in the row memory
	typedef struct packed {
		logic [MAX_WAYS-1:0]              v;
		logic [MAX_WAYS-1:0][RANK_W-1:0]  rank;
		logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

/* rtl/core/salct_ram.sv */
// Generic single-write, single-read memory with registered read data.
module salct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/salct_front.sv */
// Front end: configuration registers, item intake and address split.
module salct_front
	import salct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	input  logic                 q_full,
	output logic                 q_push,
	output acc_t                 q_entry,
	output logic [NW_W-1:0]      ways_in_use
);

	logic [2:0]        set_bits_q;
	logic [BB_W-1:0]   block_bits_q;
	logic [3:0]        ways_used_q;
	logic [SB_W-1:0]   sb;
	logic [BB_W-1:0]   bb;
	logic [SH_W-1:0]   sh;
	logic [ADDR_WIDTH-1:0] addr_m;
	logic [SET_W-1:0]  set_mask;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd4;
			block_bits_q <= BB_W'(4);
			ways_used_q  <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data[BB_W-1:0];
				REG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Clamp the fields to their meaningful ranges
	always_comb begin
		if (set_bits_q == 3'd0) begin
			sb = SB_W'(1);
		end else if (int'(set_bits_q) > MAX_SET_BITS) begin
			sb = SB_W'(MAX_SET_BITS);
		end else begin
			sb = SB_W'(set_bits_q);
		end

		if (block_bits_q == '0) begin
			bb = BB_W'(1);
		end else if (int'(block_bits_q) > BB_MAX) begin
			bb = BB_W'(BB_MAX);
		end else begin
			bb = block_bits_q;
		end

		if (ways_used_q == 4'd0) begin
			ways_in_use = NW_W'(1);
		end else if (int'(ways_used_q) > MAX_WAYS) begin
			ways_in_use = NW_W'(MAX_WAYS);
		end else begin
			ways_in_use = NW_W'(ways_used_q);
		end
	end

	// Split address into tag and set
	assign addr_m   = req.address[ADDR_WIDTH-1:0];
	assign sh       = SH_W'(sb) + SH_W'(bb);
	assign set_mask = SET_W'(((SET_W+1)'(1) << sb) - (SET_W+1)'(1));

	always_comb begin
		q_entry.tag   = TAG_W'(addr_m >> sh);
		q_entry.set   = SET_W'(addr_m >> bb) & set_mask;
		q_entry.twice = (req.opcode == OP_MODIFY);
	end

	// Fetches are taken and dropped; data accesses go to the queue
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full && (req.opcode != OP_IFETCH);

endmodule

/* rtl/core/salct_queue.sv */
// Short access queue between the front end and the tag update engine.
module salct_queue
	import salct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  acc_t push_entry,
	input  logic pop,
	output acc_t head,
	output logic empty,
	output logic full
);

	acc_t            entry_q [QDEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (Q_AW+1)'(QDEPTH));
	assign head  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

/* rtl/core/salct_back.sv */
// Back end: reads a set, does lookup and LRU update, writes it back, emits results.
module salct_back
	import salct_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [NW_W-1:0] ways_in_use,
	input  acc_t            q_head,
	input  logic            q_empty,
	output logic            q_pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rsp_t            rsp
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPD    = 3'b010,
		ST_REPEAT = 3'b100
	} state_t;

	state_t             state_q;
	acc_t               cur_q;
	logic               pass2_q;
	logic               row_ok_q;
	logic [NUM_SETS-1:0] row_valid_q;
	logic [CNT_W-1:0]   hits_q;
	logic [CNT_W-1:0]   misses_q;
	logic [CNT_W-1:0]   evicts_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               ram_re;
	logic [SET_W-1:0]   ram_raddr;
	logic [ROW_W-1:0]   ram_rdata;
	logic               ram_we;

	row_t               row;
	row_t               row_new;
	logic [MAX_WAYS-1:0] in_use;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic               hit;
	logic               found;
	logic               evict;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   free_way;
	logic [WAY_W-1:0]   victim;
	logic [RANK_W-1:0]  victim_rank;
	logic [WAY_W-1:0]   way;
	logic [RANK_W-1:0]  old_rank;
	logic               age_all;
	logic               go;
	logic               last;
	logic [CNT_W-1:0]   hits_nx;
	logic [CNT_W-1:0]   misses_nx;
	logic [CNT_W-1:0]   evicts_nx;

	// Row memory: one row per set
	salct_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q.set),
		.wdata (row_new),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign ram_re    = q_pop || (state_q == ST_REPEAT);
	assign ram_raddr = (state_q == ST_IDLE) ? q_head.set : cur_q.set;
	assign go        = (state_q == ST_UPD) && (!rsp_valid_q || !rsp_stall);
	assign ram_we    = go;
	assign last      = !(cur_q.twice && !pass2_q);

	// A never-written row reads as reset: nothing valid, all ranks zero
	always_comb begin
		row = row_t'(ram_rdata);
		if (!row_ok_q) begin
			row.v    = '0;
			row.rank = '0;
		end
	end

	// Lookup, fill choice and victim choice
	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = i < int'(ways_in_use);
			match[i]  = in_use[i] && row.v[i] && (row.tag[i] == cur_q.tag);
			free[i]   = in_use[i] && !row.v[i];
		end
		hit   = |match;
		found = |free;
		evict = !hit && !found;

		hit_way  = '0;
		free_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (free[i]) begin
				free_way = WAY_W'(i);
			end
		end

		// Oldest way in use; ties go to the lower way
		victim      = '0;
		victim_rank = row.rank[0];
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && (row.rank[i] > victim_rank)) begin
				victim      = WAY_W'(i);
				victim_rank = row.rank[i];
			end
		end

		if (hit) begin
			way = hit_way;
		end else if (found) begin
			way = free_way;
		end else begin
			way = victim;
		end
		old_rank = hit ? row.rank[hit_way] : victim_rank;
		age_all  = !hit && found;
	end

	// Recency update and refill
	always_comb begin
		row_new = row;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (WAY_W'(i) == way) begin
				row_new.rank[i] = '0;
				if (!hit) begin
					row_new.v[i]   = 1'b1;
					row_new.tag[i] = cur_q.tag;
				end
			end else if (row.v[i] && (age_all || (row.rank[i] < old_rank))) begin
				row_new.rank[i] = row.rank[i] + RANK_W'(1);
			end
		end
	end

	// Saturating totals
	always_comb begin
		hits_nx   = hits_q;
		misses_nx = misses_q;
		evicts_nx = evicts_q;
		if (hit && (hits_q != '1)) begin
			hits_nx = hits_q + CNT_W'(1);
		end
		if (!hit && (misses_q != '1)) begin
			misses_nx = misses_q + CNT_W'(1);
		end
		if (evict && (evicts_q != '1)) begin
			evicts_nx = evicts_q + CNT_W'(1);
		end
	end

	// Current access and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (go) begin
			rsp_q.hit         <= hit;
			rsp_q.miss        <= !hit;
			rsp_q.evicted     <= evict;
			rsp_q.hit_total   <= hits_nx;
			rsp_q.miss_total  <= misses_nx;
			rsp_q.evict_total <= evicts_nx;
			rsp_q.last_of_run <= last;
		end
	end

	// Sequencer, row flags, totals, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass2_q     <= 1'b0;
			row_ok_q    <= 1'b0;
			row_valid_q <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// New result loads on an update; a taken result clears
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_re) begin
				row_ok_q <= row_valid_q[ram_raddr];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						pass2_q <= 1'b0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (go) begin
						row_valid_q[cur_q.set] <= 1'b1;
						hits_q      <= hits_nx;
						misses_q    <= misses_nx;
						evicts_q    <= evicts_nx;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							pass2_q <= 1'b1;
							state_q <= ST_REPEAT;
						end
					end
				end
				ST_REPEAT: begin
					state_q <= ST_UPD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/core/set_associative_lru_cache_tags.sv */
// Top level of the set-associative LRU cache tag store.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_stall | opcode, address
//   rsp     | out       | rsp_valid / rsp_stall | hit, miss, evicted, totals, last
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// Each access passes the update engine: the set's row is read from the row
// memory, then compared, recency updated and the row written back, which waits
// while a result is held. A modify runs the update twice; an instruction fetch
// is taken and makes no result. The front end keeps taking items into a
// two-entry queue, until full, while the engine works or the result waits.
// Reset clears per-set row flags at once (no clearing pass), the totals, and
// sets the registers to 4, 4, 1.
module set_associative_lru_cache_tags
	import salct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	logic            q_push;
	acc_t            q_entry;
	logic            q_pop;
	acc_t            q_head;
	logic            q_empty;
	logic            q_full;
	logic [NW_W-1:0] ways_in_use;

	salct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.ways_in_use (ways_in_use)
	);

	salct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	salct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ways_in_use (ways_in_use),
		.q_head      (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

	// Every result is exactly one of hit or miss
	a_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.hit != rsp.miss))
		else $error("result is not exactly one of hit and miss");

	// Only a miss can evict
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.evicted) |-> rsp.miss)
		else $error("eviction reported on a hit");

	// Totals already count the access they report
	a_totals_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.hit && rsp.hit_total != '0) ||
			(rsp.miss && rsp.miss_total != '0)))
		else $error("running total misses the reported access");

	// Queue never takes an item while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("access queue overflow");

endmodule
